FILE: hdl/quaternion_to_euler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle converter
// Shared helpers that keep each concurrent check on one line.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define QTE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Working formats, constants and the arctangent table of the converter.
// ----------------------------------------------------------------------------
package qte_pkg;

   // Products and CORDIC vectors carry 30 fraction bits.
   localparam int WORK_FRAC = 30;
   localparam int WORK_W    = 38;
   // Angle accumulator, 2^32 per turn, with headroom.
   localparam int ACC_W     = 34;
   // Square root: radicand up to 2^58, root up to 2^29.
   localparam int RAD_W     = 60;
   localparam int ROOT_W    = 30;
   // Clamped yaw argument, within +-2^29.
   localparam int ARG_W     = 31;

   typedef logic signed [WORK_W-1:0] work_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic        [RAD_W-1:0]  rad_type;
   typedef logic        [ROOT_W-1:0] root_type;
   typedef logic signed [ARG_W-1:0]  arg_type;

   localparam work_type WORK_HALF     = work_type'(64'sd1 <<< (WORK_FRAC - 1));
   localparam work_type WORK_HALF_NEG = -WORK_HALF;
   localparam rad_type  RAD_ONE       = rad_type'(64'd1 << (2 * (WORK_FRAC - 1)));
   localparam acc_type  ACC_QUARTER   = acc_type'(64'sd1 <<< 30);

   // atan(2^-i) at 2^32 per turn
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

endpackage

FILE: hdl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Converts a Q2.14 quaternion into pitch, yaw and roll binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   Present a quaternion on req_comp_x/y/z/w with req_valid; it is taken at a
//   clock edge where req_valid is high and req_stall is low. One item of
//   three angles leaves on rsp_* and is taken when rsp_valid is high and
//   rsp_stall is low. Angles are binary: 2^ANGLE_WIDTH is one full turn.
//   From acceptance to rsp_valid an item passes the input capture register,
//   the product, sum, squared-sine and yaw radicand registers, 30 square
//   root stages, one quadrant stage, the CORDIC stages and the output
//   register. A new item is taken every cycle while req_stall is low.
//   A two-entry output buffer (output register plus skid register) holds
//   results while the receiver stalls; once the skid register fills, the
//   whole pipeline freezes and req_stall rises until the receiver drains it.
//   Synchronous reset clears every valid bit and the buffer; no item is lost
//   or repeated across a stall.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_defines.svh"

module quaternion_to_euler #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int ANGLE_WIDTH     = 16,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COMPONENT_WIDTH-1:0] req_comp_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_comp_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_comp_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_comp_w,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0]     rsp_pitch_angle,
   output logic signed [ANGLE_WIDTH-1:0]     rsp_yaw_angle,
   output logic signed [ANGLE_WIDTH-1:0]     rsp_roll_angle
);
   import qte_pkg::*;

   // Pipeline depth up to the last CORDIC stage.
   localparam int PIPE_N = 6 + ROOT_W + CORDIC_STAGES;
   // Stages the pitch/roll vectors and yaw sine wait for the square root.
   localparam int DLY_N  = 3 + ROOT_W;
   localparam acc_type YAW_Q = acc_type'(64'sd1 <<< (ANGLE_WIDTH - 2));
   localparam logic signed [ANGLE_WIDTH-1:0] YAW_MAX =
      ANGLE_WIDTH'(64'sd1 <<< (ANGLE_WIDTH - 2));
   localparam logic signed [ANGLE_WIDTH-1:0] YAW_MIN = -YAW_MAX;

   typedef logic signed [COMPONENT_WIDTH-1:0] comp_type;
   typedef logic signed [ANGLE_WIDTH-1:0]     angle_type;

   logic                en;
   logic [PIPE_N-1:0]   vld_ff;
   comp_type            x_ff, y_ff, z_ff, w_ff;

   work_type            p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
   work_type            sp_in, cp_in, sr_in, cr_in, diff;
   arg_type             c_in;
   work_type            sp_ff [DLY_N];
   work_type            cp_ff [DLY_N];
   work_type            sr_ff [DLY_N];
   work_type            cr_ff [DLY_N];
   arg_type             c_ff  [DLY_N];

   logic signed [2*ARG_W-1:0] c_sq_full;
   rad_type             c_sq_ff;
   rad_type             rad_ff;
   root_type            root;

   acc_type             pitch_z, yaw_z, roll_z;
   acc_type             pitch_r, yaw_r, roll_r;
   acc_type             yaw_sat;
   logic                inc;
   angle_type           pitch_in, yaw_in, roll_in;

   logic                rsp_valid_ff, skid_valid_ff;
   angle_type           out_pitch_ff, out_yaw_ff, out_roll_ff;
   angle_type           skid_pitch_ff, skid_yaw_ff, skid_roll_ff;

   // Freeze the pipeline only when both output slots are full.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_N-2:0], req_valid};
      end
   end

   // Capture the accepted quaternion.
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= req_comp_x;
         y_ff <= req_comp_y;
         z_ff <= req_comp_z;
         w_ff <= req_comp_w;
      end
   end

   // Nine component products, one register stage.
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_wx (.clock, .en, .a(w_ff), .b(x_ff), .p(p_wx));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_yz (.clock, .en, .a(y_ff), .b(z_ff), .p(p_yz));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_xx (.clock, .en, .a(x_ff), .b(x_ff), .p(p_xx));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_yy (.clock, .en, .a(y_ff), .b(y_ff), .p(p_yy));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_wz (.clock, .en, .a(w_ff), .b(z_ff), .p(p_wz));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_xy (.clock, .en, .a(x_ff), .b(y_ff), .p(p_xy));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_zz (.clock, .en, .a(z_ff), .b(z_ff), .p(p_zz));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_wy (.clock, .en, .a(w_ff), .b(y_ff), .p(p_wy));
   qte_mult #(.CW(COMPONENT_WIDTH)) u_mult_zx (.clock, .en, .a(z_ff), .b(x_ff), .p(p_zx));

   // Halved atan2 arguments; the yaw sine is clamped to one half.
   assign sp_in = p_wx + p_yz;
   assign cp_in = WORK_HALF - (p_xx + p_yy);
   assign sr_in = p_wz + p_xy;
   assign cr_in = WORK_HALF - (p_yy + p_zz);
   assign diff  = p_wy - p_zx;

   always_comb begin
      if (diff > WORK_HALF) begin
         c_in = arg_type'(WORK_HALF);
      end else if (diff < WORK_HALF_NEG) begin
         c_in = arg_type'(WORK_HALF_NEG);
      end else begin
         c_in = arg_type'(diff);
      end
   end

   // Delay line: hold the sums until the square root is ready.
   always_ff @(posedge clock) begin
      if (en) begin
         sp_ff[0] <= sp_in;
         cp_ff[0] <= cp_in;
         sr_ff[0] <= sr_in;
         cr_ff[0] <= cr_in;
         c_ff[0]  <= c_in;
         for (int k = 1; k < DLY_N; k++) begin
            sp_ff[k] <= sp_ff[k-1];
            cp_ff[k] <= cp_ff[k-1];
            sr_ff[k] <= sr_ff[k-1];
            cr_ff[k] <= cr_ff[k-1];
            c_ff[k]  <= c_ff[k-1];
         end
      end
   end

   // Yaw cosine radicand: 2^58 - c^2, over two stages.
   assign c_sq_full = c_ff[0] * c_ff[0];

   always_ff @(posedge clock) begin
      if (en) begin
         c_sq_ff <= rad_type'(c_sq_full);
         rad_ff  <= RAD_ONE - c_sq_ff;
      end
   end

   qte_isqrt u_isqrt (
      .clock,
      .en,
      .radicand (rad_ff),
      .root     (root)
   );

   // Three angle units in parallel.
   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
      .clock, .en,
      .y_in (sp_ff[DLY_N-1]), .x_in (cp_ff[DLY_N-1]), .angle (pitch_z)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
      .clock, .en,
      .y_in (work_type'(c_ff[DLY_N-1])), .x_in (work_type'(root)), .angle (yaw_z)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
      .clock, .en,
      .y_in (sr_ff[DLY_N-1]), .x_in (cr_ff[DLY_N-1]), .angle (roll_z)
   );

   // Round half up to the output angle width.
   generate
      if (ANGLE_WIDTH < 32) begin : g_round
         localparam acc_type RND = acc_type'(64'sd1 <<< (31 - ANGLE_WIDTH));
         assign pitch_r = (pitch_z + RND) >>> (32 - ANGLE_WIDTH);
         assign yaw_r   = (yaw_z   + RND) >>> (32 - ANGLE_WIDTH);
         assign roll_r  = (roll_z  + RND) >>> (32 - ANGLE_WIDTH);
      end else begin : g_full
         assign pitch_r = pitch_z;
         assign yaw_r   = yaw_z;
         assign roll_r  = roll_z;
      end
   endgenerate

   // Limit yaw to a quarter turn either way; pitch and roll wrap.
   always_comb begin
      if (yaw_r > YAW_Q) begin
         yaw_sat = YAW_Q;
      end else if (yaw_r < -YAW_Q) begin
         yaw_sat = -YAW_Q;
      end else begin
         yaw_sat = yaw_r;
      end
   end

   assign pitch_in = angle_type'(pitch_r);
   assign yaw_in   = angle_type'(yaw_sat);
   assign roll_in  = angle_type'(roll_r);
   assign inc      = en && vld_ff[PIPE_N-1];

   // Output register with skid slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff  <= skid_valid_ff || inc;
            skid_valid_ff <= 1'b0;
         end else if (inc) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_pitch_ff <= skid_pitch_ff;
            out_yaw_ff   <= skid_yaw_ff;
            out_roll_ff  <= skid_roll_ff;
         end else begin
            out_pitch_ff <= pitch_in;
            out_yaw_ff   <= yaw_in;
            out_roll_ff  <= roll_in;
         end
      end else if (inc) begin
         skid_pitch_ff <= pitch_in;
         skid_yaw_ff   <= yaw_in;
         skid_roll_ff  <= roll_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_angle = out_pitch_ff;
   assign rsp_yaw_angle   = out_yaw_ff;
   assign rsp_roll_angle  = out_roll_ff;

   `QTE_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid holds an item while the output register is empty")
   `QTE_ASSERT_NEXT(a_skid_catch, clock, reset, rsp_valid_ff && rsp_stall && vld_ff[PIPE_N-1] && !skid_valid_ff, skid_valid_ff, "item leaving the pipeline was not caught by the skid slot")
   `QTE_ASSERT_NEXT(a_frozen_valids, clock, reset, skid_valid_ff, $stable(vld_ff), "pipeline moved while frozen")
   `QTE_ASSERT_SAME(a_yaw_range, clock, reset, rsp_valid_ff, (rsp_yaw_angle <= YAW_MAX) && (rsp_yaw_angle >= YAW_MIN), "yaw beyond a quarter turn")

endmodule

FILE: hdl/qte_mult.sv
// ----------------------------------------------------------------------------
// qte_mult
// Registered product of two components, aligned to the working fraction.
// ----------------------------------------------------------------------------
module qte_mult #(
   parameter int CW = 16
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [CW-1:0]    a,
   input  logic signed [CW-1:0]    b,
   output qte_pkg::work_type       p
);
   import qte_pkg::*;

   localparam int FRAC = 2 * (CW - 2);

   logic signed [2*CW-1:0] prod_full;
   work_type               p_in;
   work_type               p_ff;

   assign prod_full = a * b;

   generate
      if (FRAC >= WORK_FRAC) begin : g_down
         // floor shift
         assign p_in = work_type'(prod_full >>> (FRAC - WORK_FRAC));
      end else begin : g_up
         assign p_in = work_type'(prod_full) <<< (WORK_FRAC - FRAC);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

FILE: hdl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module qte_isqrt (
   input  logic              clock,
   input  logic              en,
   input  qte_pkg::rad_type  radicand,
   output qte_pkg::root_type root
);
   import qte_pkg::*;

   rad_type  rem_ff [ROOT_W];
   root_type q_ff   [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_bit
         localparam int B = ROOT_W - 1 - k;
         rad_type  rem_prev;
         root_type q_prev;
         rad_type  trial;

         if (k == 0) begin : g_first
            assign rem_prev = radicand;
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign q_prev   = q_ff[k-1];
         end

         // (q + 2^B)^2 - q^2
         assign trial = (rad_type'(q_prev) << (B + 1)) + (rad_type'(1) << (2 * B));

         always_ff @(posedge clock) begin
            if (en) begin
               if (rem_prev >= trial) begin
                  rem_ff[k] <= rem_prev - trial;
                  q_ff[k]   <= q_prev | (root_type'(1) << B);
               end else begin
                  rem_ff[k] <= rem_prev;
                  q_ff[k]   <= q_prev;
               end
            end
         end
      end
   endgenerate

   assign root = q_ff[ROOT_W-1];

endmodule

FILE: hdl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) at 2^32 per turn.
// ----------------------------------------------------------------------------
module qte_cordic #(
   parameter int STAGES = 16
) (
   input  logic              clock,
   input  logic              en,
   input  qte_pkg::work_type y_in,
   input  qte_pkg::work_type x_in,
   output qte_pkg::acc_type  angle
);
   import qte_pkg::*;

   work_type x_ff    [STAGES+1];
   work_type y_ff    [STAGES+1];
   acc_type  z_ff    [STAGES+1];
   logic     zero_ff [STAGES+1];

   // Turn the left half plane by a quarter turn; flag the zero vector.
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_ff[0] <= y_in;
               y_ff[0] <= -x_in;
               z_ff[0] <= ACC_QUARTER;
            end else begin
               x_ff[0] <= -y_in;
               y_ff[0] <= x_in;
               z_ff[0] <= -ACC_QUARTER;
            end
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   genvar i;
   generate
      for (i = 0; i < STAGES; i++) begin : g_stage
         work_type dx;
         work_type dy;
         acc_type  step;

         assign dx   = y_ff[i] >>> i;
         assign dy   = x_ff[i] >>> i;
         assign step = acc_type'(ATAN_TURNS[i]);

         always_ff @(posedge clock) begin
            if (en) begin
               zero_ff[i+1] <= zero_ff[i];
               if (y_ff[i] >= 0) begin
                  x_ff[i+1] <= x_ff[i] + dx;
                  y_ff[i+1] <= y_ff[i] - dy;
                  z_ff[i+1] <= z_ff[i] + step;
               end else begin
                  x_ff[i+1] <= x_ff[i] - dx;
                  y_ff[i+1] <= y_ff[i] + dy;
                  z_ff[i+1] <= z_ff[i] - step;
               end
            end
         end
      end
   endgenerate

   assign angle = zero_ff[STAGES] ? '0 : z_ff[STAGES];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion to Euler angle converter: a local
// fixed-point predictor computes pitch, yaw and roll for every accepted item,
// and a checker compares each delivered item against the oldest prediction
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int CW        = 16;
   localparam int AW        = 16;
   localparam int STAGES    = 16;
   localparam int LATENCY   = 37 + STAGES;
   localparam int MAX_CYCLES = 400000;

   typedef logic signed [CW-1:0] comp_type;
   typedef logic signed [AW-1:0] angle_type;

   typedef struct packed {
      angle_type pitch;
      angle_type yaw;
      angle_type roll;
   } euler_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   comp_type  req_comp_x = '0, req_comp_y = '0, req_comp_z = '0, req_comp_w = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   angle_type rsp_pitch_angle, rsp_yaw_angle, rsp_roll_angle;

   // idling percentages, changed per phase
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;

   euler_type angles_due[$];
   int     errors = 0;
   int     items_sent = 0;
   int     items_checked = 0;
   longint cycle = 0;

   quaternion_to_euler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_comp_x(req_comp_x), .req_comp_y(req_comp_y),
      .req_comp_z(req_comp_z), .req_comp_w(req_comp_w),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_roll_angle(rsp_roll_angle)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor: floor shifts, 30 fraction bit products, vectoring CORDIC.
   // ------------------------------------------------------------------------
   localparam longint HALF = 64'sd1 <<< 29;

   localparam longint ARCTAN [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000
   };

   // >>> on a signed longint is already a floor shift
   function automatic longint frac30_product(longint a, longint b);
      int f;
      longint p;
      f = 2 * (CW - 2);
      p = a * b;
      if (f >= 30) return p >>> (f - 30);
      return p <<< (30 - f);
   endfunction

   function automatic longint root_floor(longint v);
      longint r, bit_w;
      r = 0;
      bit_w = 64'sd1 <<< 62;
      while (bit_w > v) bit_w = bit_w >>> 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v = v - (r + bit_w);
            r = (r >>> 1) + bit_w;
         end else begin
            r = r >>> 1;
         end
         bit_w = bit_w >>> 2;
      end
      return r;
   endfunction

   // atan2 at 2^32 per turn, then rounded half up to AW bits
   function automatic longint vector_angle(longint yv, longint xv);
      longint acc, t, dx, dy;
      acc = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         if (yv >= 0) begin
            t = xv; xv = yv; yv = -t; acc = 64'sd1 <<< 30;
         end else begin
            t = xv; xv = -yv; yv = t; acc = -(64'sd1 <<< 30);
         end
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv >= 0) begin
            xv += dx; yv -= dy; acc += ARCTAN[i];
         end else begin
            xv -= dx; yv += dy; acc -= ARCTAN[i];
         end
      end
      return (acc + (64'sd1 <<< (31 - AW))) >>> (32 - AW);
   endfunction

   function automatic euler_type euler_of(comp_type cx, comp_type cy, comp_type cz,
                                          comp_type cw);
      longint x, y, z, w, sp, cp, sr, cr, c, d, yaw, quarter;
      euler_type e;
      x = cx; y = cy; z = cz; w = cw;
      sp = frac30_product(w, x) + frac30_product(y, z);
      cp = HALF - (frac30_product(x, x) + frac30_product(y, y));
      sr = frac30_product(w, z) + frac30_product(x, y);
      cr = HALF - (frac30_product(y, y) + frac30_product(z, z));
      c  = frac30_product(w, y) - frac30_product(z, x);
      if (c > HALF) c = HALF;
      if (c < -HALF) c = -HALF;
      d = root_floor(HALF * HALF - c * c);
      yaw = vector_angle(c, d);
      quarter = 64'sd1 <<< (AW - 2);
      if (yaw > quarter) yaw = quarter;
      if (yaw < -quarter) yaw = -quarter;
      e.pitch = angle_type'(vector_angle(sp, cp));
      e.yaw   = angle_type'(yaw);
      e.roll  = angle_type'(vector_angle(sr, cr));
      return e;
   endfunction

   // ------------------------------------------------------------------------
   // Cycle counter and timeout.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Drive the receiver stall at the falling edge, per the current phase.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Check each delivered item against the oldest prediction.
   always @(posedge clock) begin
      euler_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angles_due.size() == 0) begin
            $error("unexpected item: pitch %0d yaw %0d roll %0d",
                   rsp_pitch_angle, rsp_yaw_angle, rsp_roll_angle);
            errors++;
         end else begin
            due = angles_due.pop_front();
            if (rsp_pitch_angle !== due.pitch) begin
               $error("pitch_angle: expected %0d, got %0d", due.pitch, rsp_pitch_angle);
               errors++;
            end
            if (rsp_yaw_angle !== due.yaw) begin
               $error("yaw_angle: expected %0d, got %0d", due.yaw, rsp_yaw_angle);
               errors++;
            end
            if (rsp_roll_angle !== due.roll) begin
               $error("roll_angle: expected %0d, got %0d", due.roll, rsp_roll_angle);
               errors++;
            end
            items_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Send one quaternion and hold it until accepted; valid stays high after
   // return until the next call idles or go_quiet drops it.
   // ------------------------------------------------------------------------
   task automatic send_quaternion(comp_type x, comp_type y, comp_type z, comp_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      req_comp_w <= w;
      angles_due.push_back(euler_of(x, y, z, w));
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
   endtask

   // Random component: mostly unit-range values, some full range.
   function automatic comp_type rand_comp();
      if ($urandom_range(3) == 0) return comp_type'($urandom);
      return comp_type'($signed($urandom_range(32768)) - 16384);
   endfunction

   task automatic test_directed();
      comp_type one, neg;
      one = 16'sd16384;
      neg = -16'sd16384;
      send_quaternion('0, '0, '0, '0);             // zero quaternion
      send_quaternion('0, '0, '0, one);            // identity
      send_quaternion('0, '0, '0, neg);
      send_quaternion(one, '0, '0, '0);            // pitch on negative x axis
      send_quaternion('0, '0, one, '0);            // roll on negative x axis
      send_quaternion('0, one, '0, '0);
      send_quaternion('0, 16'sd11585, '0, 16'sd11585);  // yaw at plus a quarter
      send_quaternion('0, -16'sd11585, '0, 16'sd11585); // yaw at minus a quarter
      send_quaternion('0, 16'sd32767, '0, 16'sd32767);  // argument beyond one
      send_quaternion('0, -16'sd32768, '0, 16'sd32767);
      send_quaternion(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_quaternion(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_quaternion(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
      send_quaternion(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
      send_quaternion(16'sd1, '0, 16'sd1, '0);
      send_quaternion(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192); // equal components, unit norm
      send_quaternion(16'sd11585, '0, '0, 16'sd11585);
      send_quaternion('0, '0, 16'sd11585, -16'sd11585);
      send_quaternion(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
      send_quaternion(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
      go_quiet();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count)
         send_quaternion(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      go_quiet();
   endtask

   task automatic drain();
      while (angles_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400, 0, 0);
      test_random(300, 79, 0);
      test_random(300, 0, 79);
      test_random(300, 17, 17);
      test_random(200, 0, 0);
      recv_stall_pct = 0;
      drain();
      $display("Sent %0d quaternions, %0d angle triples checked, with no idling,",
               items_sent, items_checked);
      $display("sender gaps, receiver stalls and both together.");
      if (errors == 0 && angles_due.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
